// ----- hw/rtl/ffd_pkg.sv -----
// Package for the urlencoded form field decoder.
// Shared types, character constants and register codes; no dependencies.
`default_nettype none
package ffd_pkg;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int KEY_LEN_W  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2
  } cfg_reg_t;

  // Characters of the form encoding
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    PH_MATCH = 2'd0,
    PH_SKIP  = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HEX1 = 2'd2
  } esc_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_present;
    logic       key_found;
    logic       done_res;
  } result_t;

  // Results of one body byte: up to four, in delivery order
  localparam int MAX_RES = 4;
  localparam int RES_CNT_W = 3;

  typedef struct packed {
    logic [RES_CNT_W-1:0]      count;
    result_t [MAX_RES-1:0]     item;
  } result_batch_t;

  // Result queue
  localparam int QUEUE_DEPTH = 8;
  localparam int Q_PTR_W     = 3;
  localparam int Q_CNT_W     = 4;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    return v[3:0];
  endfunction

  function automatic result_t mk_byte(input logic [7:0] b);
    result_t r;
    r.value_byte   = b;
    r.byte_present = 1'b1;
    r.key_found    = 1'b0;
    r.done_res     = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_done(input logic found);
    result_t r;
    r.value_byte   = 8'h00;
    r.byte_present = 1'b0;
    r.key_found    = found;
    r.done_res     = 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ffd_ifs.sv -----
// Valid/ready channel interfaces for body bytes and decoded results.
// No dependencies.
`default_nettype none
interface ffd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       body_end;

  modport source (output valid, output body_byte, output body_end, input ready);
  modport sink   (input valid, input body_byte, input body_end, output ready);
endinterface

interface ffd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       byte_present;
  logic       key_found;
  logic       done_res;

  modport source (output valid, output value_byte, output byte_present,
                  output key_found, output done_res, input ready);
  modport sink   (input valid, input value_byte, input byte_present,
                  input key_found, input done_res, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ffd_cfg_regs.sv -----
// Key registers of the form field decoder, with length clamp.
// Depends on ffd_pkg.
`default_nettype none
module ffd_cfg_regs #(
  parameter int KEY_MAX_BYTES = 16,
  parameter int KP_W          = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ffd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ffd_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [KEY_MAX_BYTES-1:0][7:0]       key_bytes,
  output logic [KP_W-1:0]                     key_len
);
  import ffd_pkg::*;

  logic [KEY_MAX_BYTES-1:0][7:0] key_r;
  logic [KEY_LEN_W-1:0]          klen_raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      klen_raw_r <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < KEY_MAX_BYTES; i++) begin
        if ((i < 8 && cfg_index == CFG_KEY_LOW) || (i >= 8 && cfg_index == CFG_KEY_HIGH)) begin
          key_r[i] <= cfg_data[(i & 7) * 8 +: 8];
        end
      end
      if (cfg_index == CFG_KEY_LEN) begin
        klen_raw_r <= cfg_data[KEY_LEN_W-1:0];
      end
    end
  end

  // Clamp an oversized length to the key storage
  always_comb begin
    if (klen_raw_r > KEY_LEN_W'(KEY_MAX_BYTES)) key_len = KP_W'(KEY_MAX_BYTES);
    else key_len = KP_W'(klen_raw_r);
  end

  assign key_bytes = key_r;

endmodule
`default_nettype wire

// ----- hw/rtl/ffd_parser.sv -----
// Field matcher and value decoder: parse state and one byte's results.
// Depends on ffd_pkg.
`default_nettype none
module ffd_parser #(
  parameter int KEY_MAX_BYTES = 16,
  parameter int KP_W          = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step,
  input  wire logic [7:0]               body_byte,
  input  wire logic                     body_end,
  input  wire logic [KEY_MAX_BYTES-1:0][7:0] key_bytes,
  input  wire logic [KP_W-1:0]          key_len,
  output ffd_pkg::result_batch_t        batch
);
  import ffd_pkg::*;

  phase_t            phase_r, phase_nxt, phase_upd;
  logic [KP_W-1:0]   kp_r, kp_nxt, kp_upd;
  logic              found_r, found_nxt, found_upd;
  esc_t              esc_r, esc_nxt, esc_v;
  logic [7:0]        hex_r, hex_nxt, hex_v;
  logic [7:0]        key_sel, want;
  logic [RES_CNT_W-1:0] cnt_v;
  result_t [MAX_RES-1:0] item_v;
  logic              flush_pre, plain;

  // Key byte at the match position
  always_comb begin
    key_sel = 8'h00;
    for (int i = 0; i < KEY_MAX_BYTES; i++) begin
      if (kp_r == KP_W'(i)) key_sel = key_bytes[i];
    end
    want = (kp_r < key_len) ? key_sel : CHAR_EQ;
  end

  // Next phase, match position and found flag
  always_comb begin
    phase_upd = phase_r;
    kp_upd    = kp_r;
    found_upd = found_r;
    unique case (phase_r)
      PH_MATCH: begin
        if (body_byte == CHAR_AMP) begin
          kp_upd = '0;
        end else if (kp_r > key_len || body_byte != want) begin
          phase_upd = PH_SKIP;
          kp_upd    = '0;
        end else if (kp_r == key_len) begin
          phase_upd = PH_VALUE;
          kp_upd    = '0;
          found_upd = 1'b1;
        end else begin
          kp_upd = kp_r + KP_W'(1);
        end
      end
      PH_SKIP: begin
        if (body_byte == CHAR_AMP) begin
          phase_upd = PH_MATCH;
          kp_upd    = '0;
        end
      end
      PH_VALUE: begin
        if (body_byte == CHAR_AMP) phase_upd = PH_DONE;
      end
      PH_DONE: begin
      end
    endcase
    if (body_end) begin
      phase_nxt = PH_MATCH;
      kp_nxt    = '0;
      found_nxt = 1'b0;
    end else begin
      phase_nxt = phase_upd;
      kp_nxt    = kp_upd;
      found_nxt = found_upd;
    end
  end

  // Escape decoding and result list
  always_comb begin
    esc_v     = esc_r;
    hex_v     = hex_r;
    cnt_v     = '0;
    item_v    = '0;
    flush_pre = 1'b0;
    plain     = 1'b0;
    if (phase_r == PH_VALUE) begin
      if (body_byte == CHAR_AMP) begin
        flush_pre = 1'b1;
      end else begin
        unique case (esc_r)
          ESC_NONE: plain = 1'b1;
          ESC_PCT: begin
            if (is_hex(body_byte)) begin
              hex_v = body_byte;
              esc_v = ESC_HEX1;
            end else begin
              flush_pre = 1'b1;
              plain     = 1'b1;
            end
          end
          ESC_HEX1: begin
            if (is_hex(body_byte)) begin
              item_v[cnt_v[1:0]] = mk_byte({hex_nib(hex_r), hex_nib(body_byte)});
              cnt_v = cnt_v + RES_CNT_W'(1);
              esc_v = ESC_NONE;
              hex_v = 8'h00;
            end else begin
              flush_pre = 1'b1;
              plain     = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
    // Emit a pending escape literally
    if (flush_pre) begin
      if (esc_r == ESC_PCT || esc_r == ESC_HEX1) begin
        item_v[cnt_v[1:0]] = mk_byte(CHAR_PCT);
        cnt_v = cnt_v + RES_CNT_W'(1);
      end
      if (esc_r == ESC_HEX1) begin
        item_v[cnt_v[1:0]] = mk_byte(hex_r);
        cnt_v = cnt_v + RES_CNT_W'(1);
      end
      esc_v = ESC_NONE;
      hex_v = 8'h00;
    end
    if (plain) begin
      if (body_byte == CHAR_PLUS) begin
        item_v[cnt_v[1:0]] = mk_byte(CHAR_SPACE);
        cnt_v = cnt_v + RES_CNT_W'(1);
      end else if (body_byte == CHAR_PCT) begin
        esc_v = ESC_PCT;
      end else begin
        item_v[cnt_v[1:0]] = mk_byte(body_byte);
        cnt_v = cnt_v + RES_CNT_W'(1);
      end
    end
    // End of body: flush, then the done result
    if (body_end) begin
      if (esc_v == ESC_PCT || esc_v == ESC_HEX1) begin
        item_v[cnt_v[1:0]] = mk_byte(CHAR_PCT);
        cnt_v = cnt_v + RES_CNT_W'(1);
      end
      if (esc_v == ESC_HEX1) begin
        item_v[cnt_v[1:0]] = mk_byte(hex_v);
        cnt_v = cnt_v + RES_CNT_W'(1);
      end
      item_v[cnt_v[1:0]] = mk_done(found_upd);
      cnt_v = cnt_v + RES_CNT_W'(1);
      esc_v = ESC_NONE;
      hex_v = 8'h00;
    end
    esc_nxt = esc_v;
    hex_nxt = hex_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MATCH;
      kp_r    <= '0;
      found_r <= 1'b0;
      esc_r   <= ESC_NONE;
      hex_r   <= 8'h00;
    end else if (step) begin
      phase_r <= phase_nxt;
      kp_r    <= kp_nxt;
      found_r <= found_nxt;
      esc_r   <= esc_nxt;
      hex_r   <= hex_nxt;
    end
  end

  assign batch.count = cnt_v;
  assign batch.item  = item_v;

endmodule
`default_nettype wire

// ----- hw/rtl/ffd_result_queue.sv -----
// Result queue: takes up to four results per cycle, delivers one.
// Depends on ffd_pkg.
`default_nettype none
module ffd_result_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire ffd_pkg::result_batch_t  batch,
  input  wire logic                    pop,
  output ffd_pkg::result_t             head,
  output logic [ffd_pkg::Q_CNT_W-1:0]  count
);
  import ffd_pkg::*;

  result_t              mem_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic [Q_CNT_W-1:0]   push_n;

  assign push_n = push ? Q_CNT_W'(batch.count) : '0;

  always_ff @(posedge clk) begin
    if (push) begin
      for (int j = 0; j < MAX_RES; j++) begin
        if (RES_CNT_W'(j) < batch.count) mem_r[wr_ptr_r + Q_PTR_W'(j)] <= batch.item[j];
      end
    end
  end

  always_comb begin
    count_nxt = count_r + push_n - (pop ? Q_CNT_W'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n[Q_PTR_W-1:0];
      if (pop) rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      count_r  <= count_nxt;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule
`default_nettype wire

// ----- hw/rtl/form_field_extract_decode_top.sv -----
// Top level of the urlencoded form field decoder.
// Depends on ffd_pkg, ffd_ifs, ffd_cfg_regs, ffd_parser, ffd_result_queue.
`default_nettype none
// The block reads a urlencoded form body one byte per item on in_bus and
// returns the decoded value of the first field whose name equals the
// configured key: one result per value byte ('+' as space, %XX as one byte,
// a broken escape copied literally), then a done result with the found flag
// on the last body byte, after which it rearms for the next body. Each
// accepted byte waits in the input register until the queue has room for
// four more results; its results (up to four) are then worked out in a
// single pass and pushed into an eight-entry result queue. A byte enters
// every cycle as long as the queue has room for four more results, so
// sustained rate is one byte per cycle when each byte yields at most one
// result; the single-result output port sets the limit when bytes yield
// more (escape flushes, the done result). Write the key registers only
// while no body is in flight.
module form_field_extract_decode_top #(
  parameter int KEY_MAX_BYTES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ffd_in_if.sink                              in_bus,
  ffd_out_if.source                           out_bus,
  input  wire logic                           cfg_we,
  input  wire logic [ffd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ffd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ffd_pkg::*;

  localparam int KP_W = $clog2(KEY_MAX_BYTES + 1);

  logic [KEY_MAX_BYTES-1:0][7:0] key_bytes;
  logic [KP_W-1:0]               key_len;

  // Input register
  logic       stage_v_r;
  logic [7:0] stage_byte_r;
  logic       stage_end_r;
  logic       process;
  logic       in_take;

  result_batch_t      batch;
  result_t            head;
  logic [Q_CNT_W-1:0] q_count;
  logic               pop;

  ffd_cfg_regs #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES),
    .KP_W          (KP_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_bytes (key_bytes),
    .key_len   (key_len)
  );

  // Work the staged byte only when the queue can take a full batch
  assign process      = stage_v_r && (q_count <= Q_CNT_W'(QUEUE_DEPTH - MAX_RES));
  assign in_bus.ready = !stage_v_r || process;
  assign in_take      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_take) begin
      stage_v_r <= 1'b1;
    end else if (process) begin
      stage_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_byte_r <= in_bus.body_byte;
      stage_end_r  <= in_bus.body_end;
    end
  end

  ffd_parser #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES),
    .KP_W          (KP_W)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (process),
    .body_byte (stage_byte_r),
    .body_end  (stage_end_r),
    .key_bytes (key_bytes),
    .key_len   (key_len),
    .batch     (batch)
  );

  ffd_result_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (process),
    .batch (batch),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  // Drive the result channel from the queue head
  assign out_bus.valid        = (q_count != '0);
  assign out_bus.value_byte   = head.value_byte;
  assign out_bus.byte_present = head.byte_present;
  assign out_bus.key_found    = head.key_found;
  assign out_bus.done_res     = head.done_res;
  assign pop                  = out_bus.valid && out_bus.ready;

  // Queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= Q_CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // The last body byte always produces at least the done result
  a_end_has_done: assert property (@(posedge clk) disable iff (!rst_n)
    process && stage_end_r |-> batch.count != '0)
    else $error("body end without done result");

  // A staged byte that is not worked stays staged and unchanged
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stage_v_r && !process |=> stage_v_r && $stable(stage_byte_r) && $stable(stage_end_r))
    else $error("staged byte lost");

endmodule
`default_nettype wire

// ----- tb/form_value_checker.sv -----
// Checker for the form field decoder: watches the byte, result and register ports,
// keeps its own decoder state and compares every result with the predicted one.
// Depends on ffd_pkg and ffd_ifs.
`timescale 1ns / 1ps
module form_value_checker #(
  parameter int KEY_MAX_BYTES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ffd_in_if                                   in_mon,
  ffd_out_if                                  out_mon,
  input  wire logic                           cfg_we,
  input  wire logic [ffd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ffd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  mismatches,
  output int                                  outstanding
);
  import ffd_pkg::*;

  logic [63:0] key_lo;
  logic [63:0] key_hi;
  logic [4:0]  key_len;

  phase_t      phase;
  logic [4:0]  match_pos;
  esc_t        esc;
  logic [7:0]  held_digit;
  logic        found;

  result_t     pending_results[$];
  int          errs = 0;

  function automatic int hex_val(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] key_at(int i);
    return (i < 8) ? key_lo[i*8 +: 8] : key_hi[(i-8)*8 +: 8];
  endfunction

  task automatic push_byte(logic [7:0] b);
    result_t r;
    r.value_byte   = b;
    r.byte_present = 1'b1;
    r.key_found    = 1'b0;
    r.done_res     = 1'b0;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic push_done();
    result_t r;
    r.value_byte   = 8'h00;
    r.byte_present = 1'b0;
    r.key_found    = found;
    r.done_res     = 1'b1;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic clear_parse();
    phase      = PH_MATCH;
    match_pos  = '0;
    esc        = ESC_NONE;
    held_digit = 8'h00;
    found      = 1'b0;
  endtask

  // Emit a pending escape literally.
  task automatic flush_escape();
    if (esc != ESC_NONE) push_byte(CHAR_PCT);
    if (esc == ESC_HEX1) push_byte(held_digit);
    esc        = ESC_NONE;
    held_digit = 8'h00;
  endtask

  task automatic plain_char(logic [7:0] b);
    if (b == CHAR_PLUS) push_byte(CHAR_SPACE);
    else if (b == CHAR_PCT) esc = ESC_PCT;
    else push_byte(b);
  endtask

  task automatic decode_value(logic [7:0] b);
    int lo;
    lo = hex_val(b);
    case (esc)
      ESC_NONE: plain_char(b);
      ESC_PCT: begin
        if (lo >= 0) begin
          held_digit = b;
          esc        = ESC_HEX1;
        end else begin
          flush_escape();
          plain_char(b);
        end
      end
      default: begin
        if (lo >= 0) begin
          push_byte(8'(hex_val(held_digit) * 16 + lo));
          esc        = ESC_NONE;
          held_digit = 8'h00;
        end else begin
          flush_escape();
          plain_char(b);
        end
      end
    endcase
  endtask

  task automatic decode_body_byte(logic [7:0] b, logic last);
    int         klen;
    logic [7:0] want;
    klen = (key_len > KEY_MAX_BYTES) ? KEY_MAX_BYTES : int'(key_len);
    case (phase)
      PH_MATCH: begin
        if (b == CHAR_AMP) begin
          match_pos = '0;
        end else if (match_pos > klen) begin
          phase     = PH_SKIP;
          match_pos = '0;
        end else begin
          want = (match_pos < klen) ? key_at(match_pos) : CHAR_EQ;
          if (b != want) begin
            phase     = PH_SKIP;
            match_pos = '0;
          end else if (match_pos == klen) begin
            phase     = PH_VALUE;
            match_pos = '0;
            found     = 1'b1;
          end else begin
            match_pos++;
          end
        end
      end
      PH_SKIP: begin
        if (b == CHAR_AMP) begin
          phase     = PH_MATCH;
          match_pos = '0;
        end
      end
      PH_VALUE: begin
        if (b == CHAR_AMP) begin
          flush_escape();
          phase = PH_DONE;
        end else begin
          decode_value(b);
        end
      end
      default: ;
    endcase
    if (last) begin
      flush_escape();
      push_done();
      clear_parse();
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want_r;
    if (!rst_n) begin
      key_lo  = '0;
      key_hi  = '0;
      key_len = '0;
      clear_parse();
      pending_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: value_byte %0h done_res %0b",
                 out_mon.value_byte, out_mon.done_res);
          errs++;
        end else begin
          want_r = pending_results.pop_front();
          if (out_mon.value_byte !== want_r.value_byte) begin
            $error("value_byte: expected %0h, got %0h", want_r.value_byte,
                   out_mon.value_byte);
            errs++;
          end
          if (out_mon.byte_present !== want_r.byte_present) begin
            $error("byte_present: expected %0b, got %0b", want_r.byte_present,
                   out_mon.byte_present);
            errs++;
          end
          if (out_mon.key_found !== want_r.key_found) begin
            $error("key_found: expected %0b, got %0b", want_r.key_found,
                   out_mon.key_found);
            errs++;
          end
          if (out_mon.done_res !== want_r.done_res) begin
            $error("done_res: expected %0b, got %0b", want_r.done_res,
                   out_mon.done_res);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) decode_body_byte(in_mon.body_byte, in_mon.body_end);
      // A register write takes effect for the byte after it.
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_LOW:  key_lo  = cfg_data;
          CFG_KEY_HIGH: key_hi  = cfg_data;
          CFG_KEY_LEN:  key_len = cfg_data[KEY_LEN_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches  <= errs;
    outstanding <= pending_results.size();
  end

endmodule

// ----- tb/tb_form_field_extract_decode_top.sv -----
// Testbench top for the urlencoded form field decoder: clock, reset, body stimulus,
// key register writes, output back-pressure and the final verdict.
// Depends on ffd_pkg, ffd_ifs, form_value_checker and the decoder RTL.
`timescale 1ns / 1ps
module tb_form_field_extract_decode_top;
  import ffd_pkg::*;

  localparam int KEY_MAX       = 16;
  localparam int IDLE_LIMIT    = 2000;  // cycles with no item moving on either side
  localparam int SETTLE_CYCLES = 8;     // idle time after the last result has arrived
  localparam int HOLD_CYCLES   = 64;    // long output stall, far beyond the queue depth
  localparam int PER_SETTING   = 22;    // minimum of random bytes per key setting, nine settings

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ffd_in_if  in_ch ();
  ffd_out_if out_ch ();

  int mismatches;
  int outstanding;

  // Idle rates in percent of cycles, changed between phases.
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_request = 1'b0;

  // Body under construction and a copy of the key as last written.
  logic [7:0] body_q[$];
  logic [7:0] key_mem[16];
  int         key_len_used;

  always #4 clk = ~clk;

  form_field_extract_decode_top #(.KEY_MAX_BYTES(KEY_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  form_value_checker #(.KEY_MAX_BYTES(KEY_MAX)) value_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // ---------------------------------------------------------------------------
  // Receiver: drop ready at random, or hold it low for a long stretch on request
  // so that the result queue fills and the block stalls its input.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves on either channel for too long.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Append one byte to the body under construction.
  task automatic add_body_byte(logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endtask

  // Offer one body byte, idling first at the current sender rate; return once
  // the byte has been taken. Valid stays high when the next byte follows at once.
  task automatic send_item(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.body_byte <= b;
    in_ch.body_end  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Send the built body, marking its last byte as the body end.
  task automatic send_body();
    foreach (body_q[i]) send_item(body_q[i], i == body_q.size() - 1);
    body_q.delete();
  endtask

  // Stop offering, wait until every predicted result has arrived, then let the
  // pipeline run empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write all three key registers and keep a copy for building matching fields.
  task automatic load_key(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
    write_reg(CFG_KEY_LOW, lo);
    write_reg(CFG_KEY_HIGH, hi);
    write_reg(CFG_KEY_LEN, CFG_DATA_W'(len));
    cfg_we <= 1'b0;
    for (int i = 0; i < 16; i++) key_mem[i] = (i < 8) ? lo[i*8 +: 8] : hi[(i-8)*8 +: 8];
    key_len_used = (len > KEY_MAX) ? KEY_MAX : int'(len);
  endtask

  function automatic logic [127:0] pack_key(string s);
    logic [127:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 16; i++) k[i*8 +: 8] = s[i];
    return k;
  endfunction

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) add_body_byte(s[i]);
  endtask

  // Value bytes: plain text, plus signs, good escapes, broken escapes and any
  // byte at all (an ampersand among them ends the value early).
  task automatic push_value(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: add_body_byte(CHAR_PLUS);
        1, 2: begin
          add_body_byte(CHAR_PCT);
          add_body_byte(pick_char("0123456789ABCDEFabcdef"));
          add_body_byte(pick_char("0123456789ABCDEFabcdef"));
        end
        3: begin
          add_body_byte(CHAR_PCT);
          if ($urandom_range(1)) add_body_byte(pick_char("09Afa"));
          add_body_byte(pick_char("gZ+%=x"));
        end
        4: add_body_byte(8'($urandom_range(255)));
        default: add_body_byte(pick_char("abcxyz019"));
      endcase
    end
  endtask

  // One field: mostly the key, '=' and a value; else a cut key, a key with
  // one flipped bit, or raw noise.
  task automatic push_field();
    int         kind;
    int         cut;
    logic [7:0] ch;
    kind = $urandom_range(9);
    if (kind < 6) begin
      for (int i = 0; i < key_len_used; i++) add_body_byte(key_mem[i]);
      add_body_byte(CHAR_EQ);
      push_value($urandom_range(6));
    end else if (kind == 6) begin
      cut = $urandom_range(key_len_used);
      for (int i = 0; i < cut; i++) add_body_byte(key_mem[i]);
      push_value($urandom_range(3));
    end else if (kind == 7) begin
      cut = $urandom_range(key_len_used);
      for (int i = 0; i <= key_len_used; i++) begin
        ch = (i < key_len_used) ? key_mem[i] : CHAR_EQ;
        if (i == cut) ch = ch ^ (8'h01 << $urandom_range(7));
        add_body_byte(ch);
      end
      push_value($urandom_range(3));
    end else begin
      repeat ($urandom_range(1, 6)) add_body_byte(8'($urandom_range(255)));
    end
  endtask

  // One to three fields joined by '&'; now and then cut the body short so
  // that it ends inside a key, right after '=' or inside an escape.
  task automatic push_body();
    int nf;
    int cut;
    nf = $urandom_range(1, 3);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) add_body_byte(CHAR_AMP);
      push_field();
    end
    if ($urandom_range(7) == 0 && body_q.size() > 1) begin
      cut = $urandom_range(1, body_q.size());
      while (body_q.size() > cut) void'(body_q.pop_back());
    end
    if (body_q.size() == 0) add_body_byte(8'($urandom_range(255)));
  endtask

  // Key settings: empty key, full length, a length past the maximum, short keys
  // that may hold an ampersand, raw register values and all-ones key bytes.
  task automatic pick_setting(int sel);
    logic [127:0] k;
    int           len;
    for (int i = 0; i < 16; i++) k[i*8 +: 8] = pick_char("abcd=+%");
    case (sel % 6)
      0: len = 0;
      1: len = KEY_MAX;
      2: len = (sel < 6) ? 31 : $urandom_range(KEY_MAX + 1, 31);
      3: begin
        len = $urandom_range(1, 5);
        if ($urandom_range(2) == 0) k[$urandom_range(len - 1)*8 +: 8] = CHAR_AMP;
      end
      4: begin
        k   = {$urandom, $urandom, $urandom, $urandom};
        len = $urandom_range(31);
      end
      default: begin
        k   = '1;
        len = $urandom_range(1, KEY_MAX);
      end
    endcase
    load_key(k[63:0], k[127:64], 5'(len));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [127:0] k;
    int           sent;
    in_ch.valid     <= 1'b0;
    in_ch.body_byte <= 8'h00;
    in_ch.body_end  <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_KEY_LOW;
    cfg_data        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bodies with a one-byte key.
    send_idle_pct = 21;
    recv_idle_pct = 63;
    k = pack_key("k");
    load_key(k[63:0], k[127:64], 5'd1);

    // Good escape, plus, broken escape, half escape flushed at '&', then a
    // byte after the value that must be ignored.
    push_text("k=%41+%zq%4&x");
    send_body();
    // Body ends inside the key.
    push_text("k");
    send_body();
    // Extreme bytes: 0xFF spoils the first field, 0x00 is the value.
    add_body_byte(8'hFF);
    push_text("&k=");
    add_body_byte(8'h00);
    send_body();
    // Body ends right after '=': found with an empty value.
    push_text("k=");
    send_body();

    // Shorten the key within a body: the match position now lies past it.
    settle();
    send_item("k", 1'b0);
    settle();
    load_key(k[63:0], k[127:64], 5'd0);
    send_item(CHAR_EQ, 1'b1);
    settle();

    // Hold the receiver off while a long value streams in.
    hold_request = 1'b1;
    add_body_byte(CHAR_EQ);
    repeat (40) add_body_byte(pick_char("abcdefgh"));
    send_body();

    // Random bodies: receiver-heavy idling, then sender-heavy, then none.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 21; recv_idle_pct = 63; end
        1: begin send_idle_pct = 63; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int s = 0; s < 3; s++) begin
        settle();
        pick_setting(mode * 3 + s);
        sent = 0;
        while (sent < PER_SETTING) begin
          push_body();
          sent += body_q.size();
          send_body();
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
